// ===== rtl/lmpp_pkg.sv =====
// Shared types and constants for the 3x3 local-maximum peak picker.
// No dependencies.
package lmpp_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_LEN_W  = 13;
    localparam int CFG_MRG_W  = 8;
    localparam int ROW_W      = 12;
    localparam int MAX_ROWS   = 4096;
    localparam int OUT_X_W    = 12;
    localparam int OUT_Y_W    = 12;
    localparam int OUT_H_W    = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        REG_ROW_LENGTH  = 2'd0,
        REG_ROW_COUNT   = 2'd1,
        REG_MIN_HEIGHT  = 2'd2,
        REG_EDGE_MARGIN = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_LEN_W-1:0] RESET_ROW_LENGTH  = 13'd4096;
    localparam logic [CFG_LEN_W-1:0] RESET_ROW_COUNT   = 13'd4096;
    localparam logic [CFG_MRG_W-1:0] RESET_EDGE_MARGIN = 8'd50;

endpackage

// ===== rtl/lmpp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lmpp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/local_max_peak_picker_3x3.sv =====
// Top level of the 3x3 local-maximum peak picker; uses lmpp_pkg and lmpp_ram.
// Line stores, 3x3 window, raster counters, threshold test and output register.
//
// Samples stream in raster order, one word per cycle sustained. A word taken at
// the input lands in a stage register while the two previous rows at its column
// are read from one line-store RAM (registered read); when the stage advances,
// the window compare runs and a peak, if any, is loaded into the output register.
// The input keeps accepting while a peak waits in the output register; it stalls
// only when the stage register is full and the output register is full and not
// taken. Line-store contents are undefined after reset and need no clearing pass.
module local_max_peak_picker_3x3 #(
    parameter int MAX_ROW_LENGTH = 4096,
    parameter int SAMPLE_WIDTH   = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write port
    input  logic                                  i_cfg_we,
    input  lmpp_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [lmpp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // sample stream; tdata: sample[31:0]
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [lmpp_pkg::IN_DATA_W-1:0]        i_s_tdata,
    // peak stream; tdata: peak_x[11:0], peak_y[23:12], peak_height[55:24]
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [lmpp_pkg::OUT_DATA_W-1:0]       o_m_tdata
);

    import lmpp_pkg::*;

    localparam int CW    = $clog2(MAX_ROW_LENGTH);
    localparam int LW0   = $clog2(MAX_ROW_LENGTH + 1);
    localparam int LENW  = (LW0 > CFG_LEN_W) ? LW0 : CFG_LEN_W;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int RW    = CFG_LEN_W + 1;

    typedef logic signed [SW-1:0] t_smp;

    // configuration
    logic [CFG_LEN_W-1:0]         r_row_length;
    logic [CFG_LEN_W-1:0]         r_row_count;
    logic signed [CFG_DATA_W-1:0] r_min_height;
    logic [CFG_MRG_W-1:0]         r_edge_margin;

    // counters and pipeline
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_s1_valid;
    t_smp             r_s1_sample;
    logic [CW-1:0]    r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    t_smp             r_win [6];
    logic             r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [LENW-1:0]      len_raw, len;
    logic [CFG_LEN_W-1:0] rows;
    logic [CFG_MRG_W-1:0] margin;
    logic                 accept, adv, found, size_wr;
    logic [CW:0]          col_inc;
    logic [2*SW-1:0]      ram_rdata;
    t_smp                 top, mid, bot, ctr;
    logic signed [OUT_H_W-1:0] ctr_ext;
    logic [CW-1:0]        px;
    logic [ROW_W-1:0]     py;
    logic                 in_x, in_y, greater;

    always_comb begin
        len_raw = LENW'(r_row_length);
        if (len_raw < LENW'(3)) begin
            len = LENW'(3);
        end else if (len_raw > LENW'(MAX_ROW_LENGTH)) begin
            len = LENW'(MAX_ROW_LENGTH);
        end else begin
            len = len_raw;
        end
        if (r_row_count < CFG_LEN_W'(3)) begin
            rows = CFG_LEN_W'(3);
        end else if (r_row_count > CFG_LEN_W'(MAX_ROWS)) begin
            rows = CFG_LEN_W'(MAX_ROWS);
        end else begin
            rows = r_row_count;
        end
        margin = (r_edge_margin == '0) ? CFG_MRG_W'(1) : r_edge_margin;
    end

    assign adv        = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || adv;
    assign accept     = i_s_tvalid && o_s_tready;
    assign size_wr    = i_cfg_we &&
                        (i_cfg_idx == REG_ROW_LENGTH || i_cfg_idx == REG_ROW_COUNT);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length  <= RESET_ROW_LENGTH;
            r_row_count   <= RESET_ROW_COUNT;
            r_min_height  <= '0;
            r_edge_margin <= RESET_EDGE_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_LENGTH:  r_row_length  <= i_cfg_data[CFG_LEN_W-1:0];
                REG_ROW_COUNT:   r_row_count   <= i_cfg_data[CFG_LEN_W-1:0];
                REG_MIN_HEIGHT:  r_min_height  <= $signed(i_cfg_data);
                REG_EDGE_MARGIN: r_edge_margin <= i_cfg_data[CFG_MRG_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position of the next word
    always_comb begin
        col_inc = (CW + 1)'(r_col) + (CW + 1)'(1);
        n_col   = col_inc[CW-1:0];
        n_row   = r_row;
        if (LENW'(col_inc) >= len) begin
            n_col = '0;
            if (CFG_LEN_W'(r_row) + CFG_LEN_W'(1) >= rows) begin
                n_row = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (size_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores: upper row in the high half, middle row in the low half
    lmpp_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (r_s1_col),
        .i_wdata ({mid, bot}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign top     = $signed(ram_rdata[2*SW-1:SW]);
    assign mid     = $signed(ram_rdata[SW-1:0]);
    assign bot     = r_s1_sample;
    assign ctr     = r_win[4];
    assign ctr_ext = OUT_H_W'(ctr);

    // window test
    always_comb begin
        px = r_s1_col - CW'(1);
        py = r_s1_row - ROW_W'(1);
        in_x = (LENW'(px) >= LENW'(margin)) &&
               ((LENW + 1)'(px) + (LENW + 1)'(margin) < (LENW + 1)'(len));
        in_y = (RW'(py) >= RW'(margin)) &&
               (RW'(py) + RW'(margin) < RW'(rows));
        greater = (ctr > r_win[0]) && (ctr > r_win[1]) && (ctr > r_win[2]) &&
                  (ctr > r_win[3]) && (ctr > r_win[5]) &&
                  (ctr > top) && (ctr > mid) && (ctr > bot);
        found = (r_s1_col >= CW'(2)) && (r_s1_row >= ROW_W'(2)) && in_x && in_y &&
                (ctr_ext > r_min_height) && greater;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= $signed(i_s_tdata[SW-1:0]);
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= bot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= found;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && found) begin
            r_out_data <= {ctr_ext, py[OUT_Y_W-1:0], OUT_X_W'(px)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/lmpp_checker.sv =====
// Port-level assertions for local_max_peak_picker_3x3, bound to the top level.
// Uses lmpp_pkg for field widths.
module lmpp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [lmpp_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    import lmpp_pkg::*;

    // peak word held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("peak word dropped or changed while stalled");

    // no peak word straight out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("peak valid right after reset");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // a peak centre is never on the first row
    a_peak_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_X_W+OUT_Y_W-1:OUT_X_W] != '0)
        else $error("peak reported on edge row");

endmodule

bind local_max_peak_picker_3x3 lmpp_checker u_lmpp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
